/* rtl/core/acf_pkg.sv */
// ----------------------------------------------------------------------------
// acf_pkg
// Shared types, codes and helpers of the adaptive capacity FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package acf_pkg;

    localparam int OP_W       = 2;
    localparam int PAYLOAD_W  = 64;
    localparam int REQ_CAP_W  = 11;
    localparam int STATUS_W   = 2;
    localparam int COUNT_O_W  = 10;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;
    localparam int REQ_LG_W   = 4;

    // reset value of the minimum capacity exponent
    localparam int RST_MIN_LOG2 = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_RESIZE = 2'd2
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK             = 2'd0,
        ST_PUSH_FULL      = 2'd1,
        ST_POP_EMPTY      = 2'd2,
        ST_RESIZE_REFUSED = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_CAP_LOG2    = 1'd0,
        CFG_AUTO_SHRINK_EN  = 1'd1
    } t_cfg_idx;

    // Exponent of the smallest power of two not below req (req >= 1).
    function automatic logic [REQ_LG_W-1:0] ceil_log2_req(input logic [REQ_CAP_W-1:0] req);
        logic [REQ_CAP_W-1:0] x;
        logic [REQ_LG_W-1:0]  r;
        x = req - REQ_CAP_W'(1);
        r = '0;
        for (int i = 0; i < REQ_CAP_W; i++) begin
            if (x[i]) begin
                r = REQ_LG_W'(i + 1);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/acf_req_if.sv */
// ----------------------------------------------------------------------------
// acf_req_if
// Request channel: operation words into the FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

interface acf_req_if
    import acf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [OP_W-1:0]       operation;
    logic [PAYLOAD_W-1:0]  push_value;
    logic                  allow_resize;
    logic [REQ_CAP_W-1:0]  requested_capacity;

    modport source (output valid, output operation, output push_value,
                    output allow_resize, output requested_capacity, input ready);
    modport sink   (input valid, input operation, input push_value,
                    input allow_resize, input requested_capacity, output ready);
endinterface

`default_nettype wire

/* rtl/core/acf_rsp_if.sv */
// ----------------------------------------------------------------------------
// acf_rsp_if
// Response channel: one status word per operation.
// ----------------------------------------------------------------------------
`default_nettype none

interface acf_rsp_if
    import acf_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [PAYLOAD_W-1:0]  pop_value;
    logic [COUNT_O_W-1:0]  item_count;
    logic [COUNT_O_W-1:0]  usable_capacity;
    logic                  is_empty;
    logic                  is_full;

    modport source (output valid, output status, output pop_value, output item_count,
                    output usable_capacity, output is_empty, output is_full,
                    input ready);
    modport sink   (input valid, input status, input pop_value, input item_count,
                    input usable_capacity, input is_empty, input is_full,
                    output ready);
endinterface

`default_nettype wire

/* rtl/core/acf_ram.sv */
// ----------------------------------------------------------------------------
// acf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module acf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/adaptive_capacity_fifo.sv */
// ----------------------------------------------------------------------------
// adaptive_capacity_fifo
// Order-preserving FIFO with a power-of-two logical capacity that grows on a
// full push and shrinks when underused. Data sits in one circular RAM of
// MAX_SLOTS words; a resize only changes the capacity register.
// ----------------------------------------------------------------------------
// Response path: an accepted request passes the input register, then the result
//   register with the RAM read; a stall on o_rsp holds both.
// Throughput: one operation per cycle while o_rsp.ready holds; the pointer/count
//   update is a single combinational pass, and the RAM has one write and one read port.
// Reset: synchronous, active low; empties the FIFO, capacity = 4, auto shrink
//   on. No clearing pass; storage content is never read before written.
`default_nettype none

module adaptive_capacity_fifo
    import acf_pkg::*;
#(
    parameter int MAX_SLOTS  = 1024,
    parameter int DATA_WIDTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    acf_req_if.sink                    i_req,
    acf_rsp_if.source                  o_rsp
);

    localparam int AW   = $clog2(MAX_SLOTS);
    localparam int MCL  = $clog2(MAX_SLOTS + 1) - 1;   // floor log2 of MAX_SLOTS
    localparam int CW   = MCL;                          // count up to 2**MCL - 1
    localparam int CAPW = MCL + 1;
    localparam int LW   = $clog2(MCL + 1);

    // input stage
    logic                   r_s1_vld;
    logic [OP_W-1:0]        r_s1_op;
    logic [DATA_WIDTH-1:0]  r_s1_val;
    logic                   r_s1_allow;
    logic [REQ_CAP_W-1:0]   r_s1_req;

    // FIFO state
    logic [AW-1:0]          r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]          r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]          r_count, n_count;
    logic [LW-1:0]          r_cap_lg, n_cap_lg;
    logic [LW-1:0]          r_min_lg;
    logic                   r_auto;

    // result stage
    logic                   r_out_vld;
    t_status                r_o_status;
    logic                   r_o_pop_sel;
    logic [COUNT_O_W-1:0]   r_o_count;
    logic [COUNT_O_W-1:0]   r_o_usable;
    logic                   r_o_empty;
    logic                   r_o_full;

    logic                   s2_load;
    logic                   s1_fire;
    logic [CAPW-1:0]        cap;
    logic [CAPW-1:0]        thr;
    logic                   cur_full;
    logic                   grow_ok;
    logic                   shrink_ok;
    logic                   auto_fail;
    logic [LW-1:0]          auto_cap_lg;
    logic [REQ_LG_W-1:0]    req_lg;
    logic [CAPW-1:0]        req_cap;
    logic                   req_refuse;
    logic                   do_push;
    logic                   do_pop;
    t_status                status;
    logic [CAPW-1:0]        new_cap;
    logic [DATA_WIDTH-1:0]  ram_q;
    logic [LW-1:0]          cfg_min_lg;

    assign s2_load     = !r_out_vld || o_rsp.ready;
    assign s1_fire     = r_s1_vld && s2_load;
    assign i_req.ready = !r_s1_vld || s2_load;

    // automatic rule
    always_comb begin
        cap       = CAPW'(1) << r_cap_lg;
        cur_full  = (CAPW'(r_count) == cap - CAPW'(1));
        thr       = (r_cap_lg <= r_min_lg) ? '0 : ((cap >> 1) - (cap >> 2));
        grow_ok   = (r_cap_lg != LW'(MCL));
        shrink_ok = r_auto && (r_count != '0) && (CAPW'(r_count) < thr);
        auto_fail = cur_full && !grow_ok;
        if (cur_full) begin
            auto_cap_lg = grow_ok ? r_cap_lg + LW'(1) : r_cap_lg;
        end else if (shrink_ok) begin
            // threshold is nonzero only above the minimum, so no clamp needed
            auto_cap_lg = r_cap_lg - LW'(1);
        end else begin
            auto_cap_lg = r_cap_lg;
        end
    end

    // explicit resize request
    always_comb begin
        req_lg     = ceil_log2_req(r_s1_req);
        req_cap    = CAPW'(1) << req_lg;
        req_refuse = (int'(req_lg) > MCL) || (int'(req_lg) < int'(r_min_lg))
                     || (req_cap <= CAPW'(r_count));
    end

    // operation decode
    always_comb begin
        n_cap_lg = r_cap_lg;
        status   = ST_OK;
        do_push  = 1'b0;
        do_pop   = 1'b0;
        case (r_s1_op)
            OP_PUSH: begin
                if (r_s1_allow) begin
                    n_cap_lg = auto_cap_lg;
                    if (auto_fail) begin
                        status = ST_PUSH_FULL;
                    end else begin
                        do_push = 1'b1;
                    end
                end else if (cur_full) begin
                    status = ST_PUSH_FULL;
                end else begin
                    do_push = 1'b1;
                end
            end
            OP_POP: begin
                if (r_count == '0) begin
                    status = ST_POP_EMPTY;
                end else begin
                    do_pop = 1'b1;
                end
            end
            OP_RESIZE: begin
                if (r_s1_req == '0) begin
                    n_cap_lg = auto_cap_lg;
                    if (auto_fail) begin
                        status = ST_RESIZE_REFUSED;
                    end
                end else if (req_refuse) begin
                    status = ST_RESIZE_REFUSED;
                end else begin
                    n_cap_lg = LW'(req_lg);
                end
            end
            default: begin
            end
        endcase
    end

    // next pointers and count; count never changes across a resize
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(MAX_SLOTS - 1)) ? '0 : r_wr_ptr + AW'(1);
            n_count  = r_count + CW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(MAX_SLOTS - 1)) ? '0 : r_rd_ptr + AW'(1);
            n_count  = r_count - CW'(1);
        end
        new_cap = CAPW'(1) << n_cap_lg;
    end

    assign cfg_min_lg = (int'(i_cfg_wdata) > MCL) ? LW'(MCL) : LW'(i_cfg_wdata);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_wr_ptr  <= '0;
            r_rd_ptr  <= '0;
            r_count   <= '0;
            r_cap_lg  <= LW'(RST_MIN_LOG2);
            r_min_lg  <= LW'(RST_MIN_LOG2);
            r_auto    <= 1'b1;
        end else begin
            if (i_req.ready) begin
                r_s1_vld <= i_req.valid;
            end
            if (s2_load) begin
                r_out_vld <= r_s1_vld;
            end
            if (s1_fire) begin
                r_wr_ptr <= n_wr_ptr;
                r_rd_ptr <= n_rd_ptr;
                r_count  <= n_count;
                r_cap_lg <= n_cap_lg;
            end
            // configuration is to arrive only while idle; the block itself does not enforce it
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MIN_CAP_LOG2: begin
                        r_min_lg <= cfg_min_lg;
                        r_cap_lg <= cfg_min_lg;
                        r_wr_ptr <= '0;
                        r_rd_ptr <= '0;
                        r_count  <= '0;
                    end
                    CFG_AUTO_SHRINK_EN: begin
                        r_auto <= i_cfg_wdata[0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_s1_op    <= i_req.operation;
            r_s1_val   <= i_req.push_value[DATA_WIDTH-1:0];
            r_s1_allow <= i_req.allow_resize;
            r_s1_req   <= i_req.requested_capacity;
        end
        if (s1_fire) begin
            r_o_status  <= status;
            r_o_pop_sel <= do_pop;
            r_o_count   <= COUNT_O_W'(n_count);
            r_o_usable  <= COUNT_O_W'(new_cap - CAPW'(1));
            r_o_empty   <= (n_count == '0);
            r_o_full    <= (CAPW'(n_count) == new_cap - CAPW'(1));
        end
    end

    // read word lands in the RAM output register alongside the result
    acf_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (s1_fire && do_push),
        .i_waddr (r_wr_ptr),
        .i_wdata (r_s1_val),
        .i_re    (s1_fire && do_pop),
        .i_raddr (r_rd_ptr),
        .o_rdata (ram_q)
    );

    assign o_rsp.valid           = r_out_vld;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.pop_value       = r_o_pop_sel ? PAYLOAD_W'(ram_q) : '0;
    assign o_rsp.item_count      = r_o_count;
    assign o_rsp.usable_capacity = r_o_usable;
    assign o_rsp.is_empty        = r_o_empty;
    assign o_rsp.is_full         = r_o_full;

endmodule

`default_nettype wire

/* verif/adaptive_capacity_fifo_test.sv */
// ----------------------------------------------------------------------------
// adaptive_capacity_fifo_test
// Self-checking bench for the adaptive capacity FIFO. A shadow model tracks
// the held words, the capacity and the shrink threshold, predicts every
// response word and compares it field by field. The run starts with a short
// directed sweep, then walks through several minimum-capacity and auto-shrink
// settings with random push/pop/resize traffic and random idling on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_capacity_fifo_test
    import acf_pkg::*;
();

    localparam int MAX_SLOTS    = 1024;
    localparam int WATCH_LIMIT  = 400;
    localparam int REPORT_LIMIT = 10;
    localparam int NUM_PHASES   = 10;

    // operation code the block leaves unused
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [STATUS_W-1:0]  status;
        logic [PAYLOAD_W-1:0] pop_value;
        logic [COUNT_O_W-1:0] item_count;
        logic [COUNT_O_W-1:0] usable;
        logic                 is_empty;
        logic                 is_full;
    } t_fifo_rsp;

    class fifo_shadow;
        logic [PAYLOAD_W-1:0] held[$];
        t_fifo_rsp            awaited_rsp[$];
        int unsigned          cap;
        int unsigned          shrink_at;
        int unsigned          floor_log2;
        bit                   shrink_on;
        int                   mismatches;

        function new();
            floor_log2 = RST_MIN_LOG2;
            shrink_on  = 1'b1;
            cap        = floor_cap();
            shrink_at  = 0;
            mismatches = 0;
        endfunction

        // minimum capacity, saturated at the memory size
        function int unsigned floor_cap();
            int unsigned c;
            c = 1;
            for (int i = 0; i < floor_log2 && c * 2 <= MAX_SLOTS; i++) begin
                c = c << 1;
            end
            return c;
        endfunction

        function bit at_limit();
            return held.size() == cap - 1;
        endfunction

        function void set_cap(int unsigned nc);
            cap       = nc;
            shrink_at = (cap <= floor_cap()) ? 0 : (cap / 2 - cap / 4);
        endfunction

        // grow when full, halve when underused; 0 when growth exceeds memory
        function bit auto_resize();
            int unsigned nc;
            if (at_limit()) begin
                if (cap * 2 > MAX_SLOTS) begin
                    return 1'b0;
                end
                set_cap(cap * 2);
            end else if (shrink_on && held.size() != 0 && held.size() < shrink_at) begin
                nc = cap / 2;
                if (nc < floor_cap()) begin
                    nc = floor_cap();
                end
                set_cap(nc);
            end
            return 1'b1;
        endfunction

        function void write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
            if (idx == CFG_MIN_CAP_LOG2) begin
                floor_log2 = d;
                held.delete();
                cap       = floor_cap();
                shrink_at = 0;
            end else begin
                shrink_on = d[0];
            end
        endfunction

        function void note_request(logic [OP_W-1:0] op, logic [PAYLOAD_W-1:0] val,
                                   logic allow, logic [REQ_CAP_W-1:0] req);
            t_fifo_rsp   e;
            bit          ok;
            int unsigned p;
            e.status    = ST_OK;
            e.pop_value = '0;
            case (op)
                OP_PUSH: begin
                    ok = allow ? auto_resize() : !at_limit();
                    if (ok && !at_limit()) begin
                        held.push_back(val);
                    end else begin
                        e.status = ST_PUSH_FULL;
                    end
                end
                OP_POP: begin
                    if (held.size() == 0) begin
                        e.status = ST_POP_EMPTY;
                    end else begin
                        e.pop_value = held.pop_front();
                    end
                end
                OP_RESIZE: begin
                    if (req == 0) begin
                        if (!auto_resize()) begin
                            e.status = ST_RESIZE_REFUSED;
                        end
                    end else begin
                        p = 1;
                        while (p < req && p <= MAX_SLOTS) begin
                            p = p << 1;
                        end
                        if (p > MAX_SLOTS || p < floor_cap() || p <= held.size()) begin
                            e.status = ST_RESIZE_REFUSED;
                        end else begin
                            set_cap(p);
                        end
                    end
                end
                default: ;
            endcase
            e.item_count = COUNT_O_W'(held.size());
            e.usable     = COUNT_O_W'(cap - 1);
            e.is_empty   = held.size() == 0;
            e.is_full    = at_limit();
            awaited_rsp.push_back(e);
        endfunction

        function void check_response(t_fifo_rsp got);
            t_fifo_rsp e;
            if (awaited_rsp.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: response word with nothing outstanding", $realtime);
                end
                return;
            end
            e = awaited_rsp.pop_front();
            if (got.status !== e.status || got.pop_value !== e.pop_value ||
                got.item_count !== e.item_count || got.usable !== e.usable ||
                got.is_empty !== e.is_empty || got.is_full !== e.is_full) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT) begin
                    $display("%0t: exp st=%0d pop=%h cnt=%0d use=%0d e=%0b f=%0b | got st=%0d pop=%h cnt=%0d use=%0d e=%0b f=%0b",
                             $realtime, e.status, e.pop_value, e.item_count, e.usable,
                             e.is_empty, e.is_full, got.status, got.pop_value,
                             got.item_count, got.usable, got.is_empty, got.is_full);
                end
            end
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    acf_req_if req_ch ();
    acf_rsp_if rsp_ch ();

    adaptive_capacity_fifo #(
        .MAX_SLOTS  (MAX_SLOTS),
        .DATA_WIDTH (PAYLOAD_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_ch),
        .o_rsp       (rsp_ch)
    );

    fifo_shadow shadow = new();
    t_fifo_rsp  got;
    int         req_gap_pct   = 0;
    int         rsp_stall_pct = 0;
    int         stall_left    = 0;
    int         idle_cycles   = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // sink side: random stall bursts on the response ready
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            rsp_ch.ready <= 1'b0;
        end else if (rsp_stall_pct != 0 && $urandom_range(1, 100) <= rsp_stall_pct) begin
            stall_left = $urandom_range(0, 3);
            rsp_ch.ready <= 1'b0;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.status     = rsp_ch.status;
                got.pop_value  = rsp_ch.pop_value;
                got.item_count = rsp_ch.item_count;
                got.usable     = rsp_ch.usable_capacity;
                got.is_empty   = rsp_ch.is_empty;
                got.is_full    = rsp_ch.is_full;
                shadow.check_response(got);
            end
            if (req_ch.valid && req_ch.ready) begin
                shadow.note_request(req_ch.operation, req_ch.push_value,
                                    req_ch.allow_resize, req_ch.requested_capacity);
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= WATCH_LIMIT) begin
                $display("** adaptive_capacity_fifo: FAILED **");
                $finish;
            end
        end
    end

    function automatic logic [PAYLOAD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 2))
            0:       return 0;
            1:       return 20;
            default: return 40;
        endcase
    endfunction

    task automatic send_op(logic [OP_W-1:0] op, logic [PAYLOAD_W-1:0] val,
                           logic allow, logic [REQ_CAP_W-1:0] req);
        if (req_gap_pct != 0 && $urandom_range(1, 100) <= req_gap_pct) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        req_ch.valid              <= 1'b1;
        req_ch.operation          <= op;
        req_ch.push_value         <= val;
        req_ch.allow_resize       <= allow;
        req_ch.requested_capacity <= req;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic push_word(logic [PAYLOAD_W-1:0] val, logic allow);
        send_op(OP_PUSH, val, allow, REQ_CAP_W'($urandom));
    endtask

    task automatic pop_word();
        send_op(OP_POP, rand_word(), 1'($urandom), REQ_CAP_W'($urandom));
    endtask

    task automatic resize_to(logic [REQ_CAP_W-1:0] req);
        send_op(OP_RESIZE, rand_word(), 1'($urandom), req);
    endtask

    // let the pipeline drain before touching the registers
    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (shadow.awaited_rsp.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= d;
        @(posedge i_clk);
        shadow.write_reg(idx, d);
    endtask

    task automatic configure(logic [CFG_DATA_W-1:0] floor_log2, logic shrink);
        write_reg(CFG_MIN_CAP_LOG2, floor_log2);
        write_reg(CFG_AUTO_SHRINK_EN, {{(CFG_DATA_W-1){1'b0}}, shrink});
        i_cfg_we <= 1'b0;
    endtask

    // alternating fill-heavy and drain-heavy stretches so capacity moves both ways
    task automatic mixed_traffic(int n);
        int  k;
        int  r;
        bit  filling;
        filling = $urandom_range(0, 1);
        for (int i = 0; i < n; i++) begin
            if (i % 30 == 29) begin
                filling = !filling;
            end
            k = $urandom_range(0, 99);
            if (k < (filling ? 60 : 25)) begin
                push_word(rand_word(), 1'b1);
            end else if (k < (filling ? 68 : 30)) begin
                push_word(rand_word(), 1'b0);
            end else if (k < (filling ? 88 : 85)) begin
                pop_word();
            end else if (k < 98) begin
                r = $urandom_range(0, 9);
                if (r < 3) begin
                    resize_to('0);
                end else if (r < 8) begin
                    resize_to(REQ_CAP_W'($urandom_range(1, 64)));
                end else if (r < 9) begin
                    resize_to(REQ_CAP_W'($urandom_range(65, 1024)));
                end else begin
                    resize_to(REQ_CAP_W'($urandom_range(1025, 2047)));
                end
            end else begin
                send_op(OP_UNUSED, rand_word(), 1'($urandom), REQ_CAP_W'($urandom));
            end
        end
    endtask

    int floor_set[NUM_PHASES]  = '{2, 0, 1, 3, 0, 4, 15, 10, 2, 5};
    bit shrink_set[NUM_PHASES] = '{1, 1, 0, 1, 0, 1, 0, 1, 0, 1};

    initial begin
        i_rst_n                   = 1'b0;
        i_cfg_we                  = 1'b0;
        i_cfg_idx                 = CFG_MIN_CAP_LOG2;
        i_cfg_wdata               = '0;
        req_ch.valid              = 1'b0;
        req_ch.operation          = OP_PUSH;
        req_ch.push_value         = '0;
        req_ch.allow_resize       = 1'b0;
        req_ch.requested_capacity = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed sweep from the reset state (capacity 4, no shrink threshold)
        pop_word();
        resize_to('0);
        push_word('0, 1'b0);
        push_word('1, 1'b0);
        push_word(64'h8000_0000_0000_0001, 1'b0);
        push_word(64'h0123_4567_89ab_cdef, 1'b0);
        resize_to('0);
        push_word(64'h5555_5555_5555_5555, 1'b1);
        push_word(64'haaaa_aaaa_aaaa_aaaa, 1'b1);
        resize_to(REQ_CAP_W'(2));
        resize_to(REQ_CAP_W'(5));
        resize_to(REQ_CAP_W'(4));
        resize_to(REQ_CAP_W'(MAX_SLOTS));
        resize_to(REQ_CAP_W'(MAX_SLOTS + 1));
        resize_to(REQ_CAP_W'(2047));
        send_op(OP_UNUSED, rand_word(), 1'b1, REQ_CAP_W'($urandom));
        repeat (4) pop_word();
        push_word(rand_word(), 1'b1);
        resize_to('0);
        repeat (2) pop_word();
        resize_to(REQ_CAP_W'(1));
        wait_idle();

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            if (ph == NUM_PHASES - 1) begin
                req_gap_pct   = 0;
                rsp_stall_pct = 0;
            end else begin
                req_gap_pct   = pick_pct();
                rsp_stall_pct = pick_pct();
            end
            configure(CFG_DATA_W'(floor_set[ph]), shrink_set[ph]);
            mixed_traffic(42);
            wait_idle();
        end

        repeat (8) @(posedge i_clk);
        if (shadow.mismatches == 0 && shadow.awaited_rsp.size() == 0) begin
            $display("** adaptive_capacity_fifo: PASSED **");
        end else begin
            $display("** adaptive_capacity_fifo: FAILED **");
        end
        $finish;
    end

endmodule

`default_nettype wire
